[rtl/core/page_cache_lru_tag_engine_unit_assert.svh]
// Assertion macros for the page cache tag engine.
// Used by the top level; expects clk and rst in scope.
`ifndef PAGE_CACHE_LRU_TAG_ENGINE_UNIT_ASSERT_SVH
`define PAGE_CACHE_LRU_TAG_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PCLTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCLTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCLTE_ASSERT(lbl, prop, msg)
`define PCLTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/pclte_pkg.sv]
// Shared constants and types for the page cache tag engine.
// No dependencies.
`default_nettype none
package pclte_pkg;
  localparam int ENTRIES_DEF    = 512;
  localparam int STAMP_BITS_DEF = 64;
  localparam int KEY_W          = 32;
  localparam int PAGE_W         = 32;
  localparam int SLOT_W         = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;
endpackage
`default_nettype wire

[rtl/core/pclte_if.sv]
// Valid/ready channel interfaces for access requests and lookup responses.
// Depends on pclte_pkg.
`default_nettype none
interface pclte_in_if
  import pclte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [KEY_W-1:0]  file_key;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output operation, output file_key, output page_number,
                  input ready);
  modport sink   (input valid, input operation, input file_key, input page_number,
                  output ready);
endinterface

interface pclte_out_if
  import pclte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              needs_writeback;
  logic [KEY_W-1:0]  victim_file_key;
  logic [PAGE_W-1:0] victim_page_number;

  modport source (output valid, output hit, output slot, output needs_writeback,
                  output victim_file_key, output victim_page_number, input ready);
  modport sink   (input valid, input hit, input slot, input needs_writeback,
                  input victim_file_key, input victim_page_number, output ready);
endinterface
`default_nettype wire

[rtl/core/pclte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pclte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/page_cache_lru_tag_engine_unit.sv]
// Tag and LRU replacement engine for a fully associative write-back page cache.
// Depends on pclte_pkg, pclte_if, pclte_ram and the assertion header.
//
// Usage:
//   req carries one access (operation, file_key, page_number); rsp returns one
//   result per access (hit, slot, needs_writeback, victim tag).
//   Slots fill in index order and never empty, so a fill count marks the valid
//   slots. Tags, dirty flags and stamps sit in one RAM with one read port.
//   The sequencer reads one filled slot per cycle, comparing the tag and
//   tracking the oldest stamp.
//   An access goes from idle to a scan of the filled slots, which stops at
//   the first tag hit and is skipped when no slot is filled, then to an
//   update step that writes the slot and registers the result.
//   req.ready is high only while no access is being worked on.
//   The result register lets the next access be accepted while a result waits;
//   that access holds in its update step until rsp is taken.
//   Reset: all slots empty, tick counter zero, no result pending; no clearing
//   pass is needed.
`default_nettype none
module page_cache_lru_tag_engine_unit
  import pclte_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pclte_in_if.sink    req,
  pclte_out_if.source rsp
);
  `include "page_cache_lru_tag_engine_unit_assert.svh"

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = KEY_W + PAGE_W + 1 + STAMP_BITS;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  state_t state, state_next;

  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic [PAGE_W-1:0] page_r;

  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      issue_cnt;
  logic [ADDR_W-1:0]     chk_idx;
  logic                  chk_pend;
  logic [STAMP_BITS-1:0] tick;

  logic              hit_r;
  logic [ADDR_W-1:0] hit_idx;
  logic              hit_dirty;

  logic [ADDR_W-1:0]     best_idx;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  best_dirty;
  logic [KEY_W-1:0]      best_key;
  logic [PAGE_W-1:0]     best_page;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic              upd_fire;

  logic [KEY_W-1:0]      e_key;
  logic [PAGE_W-1:0]     e_page;
  logic                  e_dirty;
  logic [STAMP_BITS-1:0] e_stamp;
  logic                  e_match;
  logic                  last_chk;
  logic                  issue_more;

  logic [ADDR_W-1:0]     vic_idx;
  logic                  wb;
  logic                  new_dirty;
  logic [STAMP_BITS-1:0] stamp_new;

  pclte_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_tags (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(vic_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign e_key   = rd_data[WORD_W-1 -: KEY_W];
  assign e_page  = rd_data[STAMP_BITS+1 +: PAGE_W];
  assign e_dirty = rd_data[STAMP_BITS];
  assign e_stamp = rd_data[STAMP_BITS-1:0];

  assign e_match    = chk_pend && (e_key == key_r) && (e_page == page_r);
  assign last_chk   = chk_pend && ((CNT_W'(chk_idx) + CNT_W'(1)) == fill);
  assign issue_more = issue_cnt != fill;
  assign rd_addr    = issue_cnt[ADDR_W-1:0];

  always_comb begin
    if (hit_r) begin
      vic_idx = hit_idx;
    end else if (fill != FULL) begin
      vic_idx = fill[ADDR_W-1:0];
    end else begin
      vic_idx = best_idx;
    end
  end

  assign wb        = !hit_r && (fill == FULL) && best_dirty;
  assign new_dirty = (hit_r && hit_dirty) || (op_r == OP_WRITE);
  assign stamp_new = tick + ((op_r == OP_WRITE) ? STAMP_BITS'(2) : STAMP_BITS'(1));
  assign wr_data   = {key_r, page_r, new_dirty, stamp_new};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (fill == '0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (e_match || last_chk) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    upd_fire  = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_SCAN:   rd_en     = issue_more;
      ST_UPDATE: upd_fire  = !rsp.valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign wr_en = upd_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      tick      <= '0;
      chk_pend  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state    <= state_next;
      chk_pend <= rd_en && (state_next == ST_SCAN);
      if (upd_fire) begin
        tick <= stamp_new;
        if (!hit_r && fill != FULL) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (upd_fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r      <= op_t'(req.operation);
      key_r     <= req.file_key;
      page_r    <= req.page_number;
      issue_cnt <= '0;
      hit_r     <= 1'b0;
    end
    if (rd_en) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
      chk_idx   <= issue_cnt[ADDR_W-1:0];
    end
    if (state == ST_SCAN && chk_pend) begin
      if (e_match) begin
        hit_r     <= 1'b1;
        hit_idx   <= chk_idx;
        hit_dirty <= e_dirty;
      end
      if (chk_idx == '0 || e_stamp < best_stamp) begin
        best_idx   <= chk_idx;
        best_stamp <= e_stamp;
        best_dirty <= e_dirty;
        best_key   <= e_key;
        best_page  <= e_page;
      end
    end
    if (upd_fire) begin
      rsp.hit                <= hit_r;
      rsp.slot               <= SLOT_W'(vic_idx);
      rsp.needs_writeback    <= wb;
      rsp.victim_file_key    <= wb ? best_key : '0;
      rsp.victim_page_number <= wb ? best_page : '0;
    end
  end

  `PCLTE_ASSERT(a_wb_only_full_miss, rsp.valid && rsp.needs_writeback |-> !rsp.hit && fill == FULL, "writeback reported outside a full-cache miss")
  `PCLTE_ASSERT(a_fill_grows_on_miss, upd_fire && !hit_r && fill != FULL |=> fill == $past(fill) + CNT_W'(1), "fill count did not advance on a free-slot miss")
  `PCLTE_ASSERT(a_tick_only_on_update, !upd_fire |=> $stable(tick), "tick counter moved outside an update")
endmodule
`default_nettype wire
